// ===== src/aes256_pkg.sv =====
`timescale 1ns / 1ps
package aes256_pkg;

  localparam int NumRounds = 14;

  typedef logic [127:0] block_t;
  typedef logic [255:0] key_t;
  typedef logic [7:0]   byte_t;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  localparam logic [1:0] RegKey0 = 2'd0;
  localparam logic [1:0] RegKey1 = 2'd1;
  localparam logic [1:0] RegKey2 = 2'd2;
  localparam logic [1:0] RegKey3 = 2'd3;

  localparam byte_t Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic byte_t xtime(byte_t x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  // byte i of the block sits at bits 127-8i
  function automatic block_t sbox_layer(block_t s, logic inv);
    block_t r;
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = inv ? InvSbox[s[8*i +: 8]] : Sbox[s[8*i +: 8]];
    end
    sbox_layer = r;
  endfunction

  function automatic block_t row_rotate(block_t s, logic inv);
    block_t r;
    for (int rw = 0; rw < 4; rw++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv)
          r[127 - 8*(rw + 4*((c + rw) % 4)) -: 8] = s[127 - 8*(rw + 4*c) -: 8];
        else
          r[127 - 8*(rw + 4*c) -: 8] = s[127 - 8*(rw + 4*((c + rw) % 4)) -: 8];
      end
    end
    row_rotate = r;
  endfunction

  function automatic block_t column_mix(block_t s, logic inv);
    block_t r;
    byte_t a, b, c, d, e, z, x, y;
    for (int k = 0; k < 4; k++) begin
      a = s[127 - 32*k -: 8];
      b = s[119 - 32*k -: 8];
      c = s[111 - 32*k -: 8];
      d = s[103 - 32*k -: 8];
      e = a ^ b ^ c ^ d;
      if (inv) begin
        z = xtime(e);
        x = e ^ xtime(xtime(z ^ a ^ c));
        y = e ^ xtime(xtime(z ^ b ^ d));
      end else begin
        z = 8'h00;
        x = e;
        y = e;
      end
      r[127 - 32*k -: 8] = a ^ x ^ xtime(a ^ b);
      r[119 - 32*k -: 8] = b ^ y ^ xtime(b ^ c);
      r[111 - 32*k -: 8] = c ^ x ^ xtime(c ^ d);
      r[103 - 32*k -: 8] = d ^ y ^ xtime(d ^ a);
    end
    column_mix = r;
  endfunction

endpackage

// ===== src/aes256_round.sv =====
`timescale 1ns / 1ps
// one pipeline stage: a cipher round plus one step of the key expansion.
// the key window holds two consecutive round keys {rk_a, rk_b}
module aes256_round #(
  parameter int Step = 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic                cmd,
  input  aes256_pkg::block_t  state,
  input  aes256_pkg::key_t    win,
  output logic                cmd_q,
  output aes256_pkg::block_t  state_q,
  output aes256_pkg::key_t    win_q
);

  localparam logic [7:0] Rcon = 8'h01 << ((Step - 1) / 2);
  // backward schedule recovers round key 13-Step from round keys 14-Step and 15-Step
  localparam logic [7:0] RconRev = 8'h01 << ((aes256_pkg::NumRounds - 1 - Step) / 2);
  localparam bit OddStep = (Step % 2) == 1;
  localparam bit LastStep = Step == aes256_pkg::NumRounds;

  logic [127:0] ka, kb, kn;
  logic [31:0]  tf;
  aes256_pkg::block_t s1, s2, s3, s_next;
  aes256_pkg::key_t win_next;

  assign ka = win[255:128];
  assign kb = win[127:0];

  // forward: next key from ka, kb; reverse: previous key from ka, kb
  always_comb begin
    logic [31:0] w0, w1, w2, w3;
    if (cmd == aes256_pkg::CmdEncrypt) begin
      tf = OddStep ? aes256_pkg::sub_word({kb[23:0], kb[31:24]}) ^ {Rcon, 24'h0}
                   : aes256_pkg::sub_word(kb[31:0]);
      w0 = ka[127:96] ^ tf;
      w1 = ka[95:64] ^ w0;
      w2 = ka[63:32] ^ w1;
      w3 = ka[31:0] ^ w2;
      kn = {w0, w1, w2, w3};
      win_next = {kb, kn};
    end else begin
      // window is {k[i], k[i+1]}, recover k[i-1]
      w3 = kb[31:0] ^ kb[63:32];
      w2 = kb[63:32] ^ kb[95:64];
      w1 = kb[95:64] ^ kb[127:96];
      tf = OddStep ? aes256_pkg::sub_word({ka[23:0], ka[31:24]}) ^ {RconRev, 24'h0}
                   : aes256_pkg::sub_word(ka[31:0]);
      w0 = kb[127:96] ^ tf;
      kn = {w0, w1, w2, w3};
      win_next = {kn, ka};
    end
  end

  always_comb begin
    if (cmd == aes256_pkg::CmdEncrypt) begin
      s1 = aes256_pkg::sbox_layer(state, 1'b0);
      s2 = aes256_pkg::row_rotate(s1, 1'b0);
      s3 = LastStep ? s2 : aes256_pkg::column_mix(s2, 1'b0);
      s_next = s3 ^ kb;
    end else begin
      // state already has rk[i+1] added; finish inverse round to rk[i]
      s1 = aes256_pkg::row_rotate(state, 1'b1);
      s2 = aes256_pkg::sbox_layer(s1, 1'b1);
      s3 = s2 ^ ka;
      s_next = LastStep ? s3 : aes256_pkg::column_mix(s3, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_q   <= cmd;
      state_q <= s_next;
      win_q   <= win_next;
    end
  end

endmodule

// ===== src/aes256_block_cipher.sv =====
`timescale 1ns / 1ps
// aes-256 encrypt/decrypt pipeline, one block per cycle.
// input channel: in_valid/in_ready carry cmd (0 encrypt, 1 decrypt) and the
// block as block_hi (bytes 0..7) and block_lo (bytes 8..15).
// output channel: out_valid/out_ready carry result_hi and result_lo.
// key: cfg_we writes cfg_data into key register cfg_index (0..3); other
// indexes are ignored. write only while the pipeline is empty.
// structure: one input stage that adds the first round key, then fourteen
// round stages, each also expanding the key by one round key.
// throughput: one block per cycle; the whole pipeline advances as one, so
// when out_ready is low with a result waiting, every stage holds and
// in_ready drops; nothing is lost or repeated.
// decrypt starts from round keys 13 and 14, which a small sequencer expands
// from the stored key one round key per cycle; after reset and after every
// key write in_ready stays low while it runs.
// reset clears the key registers and every valid bit.
module aes256_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [63:0] block_hi,
  input  logic [63:0] block_lo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_hi,
  output logic [63:0] result_lo,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int Nr = aes256_pkg::NumRounds;

  logic [63:0] key_word [4];
  logic [Nr:0] vld;
  logic        adv;
  logic        cmd_s [Nr+1];
  aes256_pkg::block_t st_s [Nr+1];
  aes256_pkg::key_t   win_s [Nr+1];
  aes256_pkg::key_t   key_all, win0;
  aes256_pkg::block_t blk;
  logic [3:0]         exp_cnt;
  logic [3:0]         exp_round;
  logic               exp_busy;
  aes256_pkg::key_t   dec_key, dec_key_next;

  assign adv      = !vld[Nr] || out_ready;
  assign in_ready = adv && !exp_busy;
  assign out_valid = vld[Nr];
  assign result_hi = st_s[Nr][127:64];
  assign result_lo = st_s[Nr][63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word <= '{default: 64'h0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes256_pkg::RegKey0: key_word[0] <= cfg_data;
        aes256_pkg::RegKey1: key_word[1] <= cfg_data;
        aes256_pkg::RegKey2: key_word[2] <= cfg_data;
        aes256_pkg::RegKey3: key_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign key_all = {key_word[0], key_word[1], key_word[2], key_word[3]};

  // exp_cnt == Nr loads the stored key, then each count expands one round key
  assign exp_busy  = exp_cnt != 4'd0;
  assign exp_round = 4'(Nr) - exp_cnt;

  always_comb begin
    logic [31:0] t, a0, a1, a2, a3;
    if (exp_round[0])
      t = aes256_pkg::sub_word({dec_key[23:0], dec_key[31:24]}) ^
          {8'h01 << exp_round[3:1], 24'h0};
    else
      t = aes256_pkg::sub_word(dec_key[31:0]);
    a0 = dec_key[255:224] ^ t;
    a1 = dec_key[223:192] ^ a0;
    a2 = dec_key[191:160] ^ a1;
    a3 = dec_key[159:128] ^ a2;
    dec_key_next = {dec_key[127:0], a0, a1, a2, a3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_cnt <= 4'(Nr);
    end else if (cfg_we) begin
      exp_cnt <= 4'(Nr);
    end else if (exp_cnt == 4'(Nr)) begin
      dec_key <= key_all;
      exp_cnt <= exp_cnt - 4'd1;
    end else if (exp_busy) begin
      dec_key <= dec_key_next;
      exp_cnt <= exp_cnt - 4'd1;
    end
  end

  assign blk  = {block_hi, block_lo};
  assign win0 = (cmd == aes256_pkg::CmdEncrypt) ? key_all : dec_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Nr-1:0], in_valid && !exp_busy};
    end
  end

  // input stage: encrypt adds rk0, decrypt adds rk14 and keeps {rk13,rk14}
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_s[0] <= cmd;
      if (cmd == aes256_pkg::CmdEncrypt) begin
        st_s[0]  <= blk ^ key_all[255:128];
        win_s[0] <= key_all;
      end else begin
        st_s[0]  <= blk ^ dec_key[127:0];
        win_s[0] <= win0;
      end
    end
  end

  for (genvar g = 1; g <= Nr; g++) begin : g_round
    aes256_round #(.Step(g)) u_round (
      .clk    (clk),
      .en     (adv),
      .cmd    (cmd_s[g-1]),
      .state  (st_s[g-1]),
      .win    (win_s[g-1]),
      .cmd_q  (cmd_s[g]),
      .state_q(st_s[g]),
      .win_q  (win_s[g])
    );
  end

`ifndef SYNTHESIS
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    (in_ready == (!exp_busy && (!out_valid || out_ready))))
    else $error("in_ready disagrees with output stall");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_hi) && $stable(result_lo)))
    else $error("stalled result changed");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted item not captured");
`endif

endmodule

// ===== verif/aes256_block_cipher_checker.sv =====
`timescale 1ns / 1ps
module aes256_block_cipher_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [63:0] block_hi,
  input  logic [63:0] block_lo,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] result_hi,
  input  logic [63:0] result_lo,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          pending,
  output int          errors
);

  // byte i of the block is element i, byte 0 in the top bits
  typedef logic [0:15][7:0] state_t;

  logic [63:0]        key_regs [4];
  aes256_pkg::byte_t  sub_fwd [256];
  aes256_pkg::byte_t  sub_inv [256];
  aes256_pkg::block_t expected_blocks [$];

  function automatic aes256_pkg::byte_t gf_dbl(aes256_pkg::byte_t x);
    gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic aes256_pkg::byte_t gf_mul(aes256_pkg::byte_t a, aes256_pkg::byte_t b);
    aes256_pkg::byte_t p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) p ^= a;
      a = gf_dbl(a);
      b = b >> 1;
    end
    gf_mul = p;
  endfunction

  function automatic aes256_pkg::byte_t rotl(aes256_pkg::byte_t x, int n);
    rotl = (x << n) | (x >> (8 - n));
  endfunction

  // s-box from x^254 and the affine map, independent of the rtl tables
  initial begin
    aes256_pkg::byte_t inv, p, base;
    for (int v = 0; v < 256; v++) begin
      p = 8'h01;
      base = v[7:0];
      for (int e = 0; e < 8; e++) begin
        if (e != 0) p = gf_mul(p, base);
        base = gf_mul(base, base);
      end
      inv = p;
      sub_fwd[v] = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
    end
    for (int v = 0; v < 256; v++) sub_inv[sub_fwd[v]] = v[7:0];
  end

  function automatic state_t sub_state(state_t s, logic inv);
    for (int i = 0; i < 16; i++) s[i] = inv ? sub_inv[s[i]] : sub_fwd[s[i]];
    sub_state = s;
  endfunction

  function automatic state_t rotate_rows(state_t s, logic inv);
    state_t r;
    for (int rw = 0; rw < 4; rw++)
      for (int c = 0; c < 4; c++) begin
        if (inv) r[rw + 4*((c + rw) % 4)] = s[rw + 4*c];
        else r[rw + 4*c] = s[rw + 4*((c + rw) % 4)];
      end
    rotate_rows = r;
  endfunction

  function automatic state_t mix_state(state_t s, logic inv);
    aes256_pkg::byte_t a, b, c, d, e, z, x, y;
    for (int i = 0; i < 16; i += 4) begin
      a = s[i]; b = s[i+1]; c = s[i+2]; d = s[i+3];
      e = a ^ b ^ c ^ d;
      x = e;
      y = e;
      if (inv) begin
        z = gf_dbl(e);
        x = e ^ gf_dbl(gf_dbl(z ^ a ^ c));
        y = e ^ gf_dbl(gf_dbl(z ^ b ^ d));
      end
      s[i]   = a ^ x ^ gf_dbl(a ^ b);
      s[i+1] = b ^ y ^ gf_dbl(b ^ c);
      s[i+2] = c ^ x ^ gf_dbl(c ^ d);
      s[i+3] = d ^ y ^ gf_dbl(d ^ a);
    end
    mix_state = s;
  endfunction

  function automatic aes256_pkg::block_t aes_transform(logic op, aes256_pkg::block_t blk);
    logic [0:239][7:0] rk;
    aes256_pkg::byte_t t [4];
    aes256_pkg::byte_t rc, tmp;
    state_t st, rkey;
    rc = 8'h01;
    for (int i = 0; i < 32; i++) rk[i] = key_regs[i / 8][63 - 8*(i % 8) -: 8];
    for (int i = 32; i < 240; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = rk[i - 4 + j];
      if (i % 32 == 0) begin
        tmp = t[0];
        t[0] = sub_fwd[t[1]] ^ rc;
        t[1] = sub_fwd[t[2]];
        t[2] = sub_fwd[t[3]];
        t[3] = sub_fwd[tmp];
        rc = gf_dbl(rc);
      end else if (i % 32 == 16) begin
        for (int j = 0; j < 4; j++) t[j] = sub_fwd[t[j]];
      end
      for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 32 + j] ^ t[j];
    end
    st = blk;
    if (op == aes256_pkg::CmdEncrypt) begin
      st ^= rk[0 +: 16];
      for (int rnd = 1; rnd <= aes256_pkg::NumRounds; rnd++) begin
        st = rotate_rows(sub_state(st, 1'b0), 1'b0);
        if (rnd < aes256_pkg::NumRounds) st = mix_state(st, 1'b0);
        rkey = rk[16*rnd +: 16];
        st ^= rkey;
      end
    end else begin
      rkey = rk[16*aes256_pkg::NumRounds +: 16];
      st ^= rkey;
      st = sub_state(rotate_rows(st, 1'b1), 1'b1);
      for (int rnd = aes256_pkg::NumRounds - 1; rnd > 0; rnd--) begin
        rkey = rk[16*rnd +: 16];
        st = mix_state(st ^ rkey, 1'b1);
        st = sub_state(rotate_rows(st, 1'b1), 1'b1);
      end
      st ^= rk[0 +: 16];
    end
    aes_transform = st;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    for (int i = 0; i < 4; i++) key_regs[i] = 64'h0;
  end

  always @(posedge clk) begin
    aes256_pkg::block_t want;
    if (rst) begin
      for (int i = 0; i < 4; i++) key_regs[i] = 64'h0;
      expected_blocks.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("unexpected result %h_%h at %0t", result_hi, result_lo, $realtime);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          if (result_hi !== want[127:64]) report_mismatch("result_hi", result_hi, want[127:64]);
          if (result_lo !== want[63:0]) report_mismatch("result_lo", result_lo, want[63:0]);
        end
      end
      if (in_valid && in_ready)
        expected_blocks.push_back(aes_transform(cmd, {block_hi, block_lo}));
      if (cfg_we) key_regs[cfg_index] = cfg_data;
    end
    pending = expected_blocks.size();
  end

endmodule

// ===== verif/aes256_block_cipher_tb.sv =====
`timescale 1ns / 1ps
module aes256_block_cipher_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = aes256_pkg::CmdEncrypt;
  logic [63:0] block_hi = '0;
  logic [63:0] block_lo = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = aes256_pkg::RegKey0;
  logic [63:0] cfg_data = '0;
  int          pending;
  int          errors;
  logic        calm = 1'b0;

  always #5 clk = ~clk;

  aes256_block_cipher dut (.*);

  aes256_block_cipher_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .cmd, .block_hi, .block_lo,
    .out_valid, .out_ready, .result_hi, .result_lo,
    .cfg_we, .cfg_index, .cfg_data, .pending, .errors
  );

  // receiver stalls at random, 16 percent of the time, unless calm
  always @(negedge clk) out_ready = calm || ($urandom_range(99) >= 16);

  function automatic logic [63:0] rand64();
    rand64 = {$urandom, $urandom};
  endfunction

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send_block(logic op, logic [63:0] hi, logic [63:0] lo);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = op;
    block_hi = hi;
    block_lo = lo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
    logic [63:0] words [4];
    words = '{k0, k1, k2, k3};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we = 1'b1;
      cfg_index = i[1:0];
      cfg_data = words[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  task automatic directed_items();
    send_block(aes256_pkg::CmdEncrypt, 64'h0, 64'h0);
    send_block(aes256_pkg::CmdDecrypt, 64'h0, 64'h0);
    send_block(aes256_pkg::CmdEncrypt, '1, '1);
    send_block(aes256_pkg::CmdDecrypt, '1, '1);
    send_block(aes256_pkg::CmdEncrypt, 64'h8000_0000_0000_0000, 64'h1);
    send_block(aes256_pkg::CmdDecrypt, 64'h1, 64'h8000_0000_0000_0000);
    send_block(aes256_pkg::CmdEncrypt, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block(aes256_pkg::CmdDecrypt, 64'h8ea2_b7ca_5167_45bf, 64'heafc_4990_4b49_6089);
  endtask

  task automatic random_items(int count);
    logic [63:0] hi, lo;
    for (int n = 0; n < count; n++) begin
      hi = rand64();
      lo = rand64();
      case ($urandom_range(19))
        0: hi = '0;
        1: lo = '1;
        2: begin hi = '1; lo = '0; end
        default: ;
      endcase
      send_block(1'($urandom_range(1)), hi, lo);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // key never written reads as zero
    directed_items();
    random_items(100);
    load_key('1, '1, '1, '1);
    directed_items();
    random_items(120);
    drain();
    random_items(120);
    load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
             64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f);
    directed_items();
    calm = 1'b1;
    random_items(300);
    calm = 1'b0;
    for (int p = 0; p < 4; p++) begin
      load_key(rand64(), rand64(), rand64(), rand64());
      random_items(207);
    end
    load_key(rand64(), rand64(), 64'h0, 64'h0);
    random_items(100);
    load_key('0, '0, '0, '0);
    random_items(60);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== aes256_block_cipher.f =====
src/aes256_pkg.sv
src/aes256_round.sv
src/aes256_block_cipher.sv
verif/aes256_block_cipher_checker.sv
verif/aes256_block_cipher_tb.sv
